### design/pbsc_pkg.sv
`timescale 1ns / 1ps

package pbsc_pkg;

    localparam int TimerW = 16;
    localparam int KeyW   = 10;

    localparam logic [TimerW-1:0] TIMER_MAX   = '1;
    localparam logic [KeyW-1:0]   ALT_KEY     = 10'd102;

    // reset values of the configuration registers
    localparam logic [TimerW-1:0] LONG_PRESS_RST   = 16'd1000;
    localparam logic [TimerW-1:0] RESUME_IGN_RST   = 16'd500;
    localparam logic [TimerW-1:0] RETRY_INTV_RST   = 16'd2000;
    localparam logic [TimerW-1:0] ERROR_AFTER_RST  = 16'd30000;
    localparam logic [KeyW-1:0]   POWER_KEY_RST    = 10'd116;

    // configuration register indexes
    localparam logic [2:0] CFG_LONG_PRESS  = 3'd0;
    localparam logic [2:0] CFG_RESUME_IGN  = 3'd1;
    localparam logic [2:0] CFG_RETRY_INTV  = 3'd2;
    localparam logic [2:0] CFG_ERROR_AFTER = 3'd3;
    localparam logic [2:0] CFG_POWER_KEY   = 3'd4;

    // operations
    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_KEY     = 2'd1;
    localparam logic [1:0] OP_OUTCOME = 2'd2;

    // key values
    localparam logic [1:0] KEY_RELEASE = 2'd0;
    localparam logic [1:0] KEY_PRESS   = 2'd1;

    // actions
    localparam logic [2:0] ACT_NONE     = 3'd0;
    localparam logic [2:0] ACT_SLEEP    = 3'd1;
    localparam logic [2:0] ACT_SHUTDOWN = 3'd2;
    localparam logic [2:0] ACT_FAKE_ON  = 3'd3;
    localparam logic [2:0] ACT_FAKE_OFF = 3'd4;
    localparam logic [2:0] ACT_ERROR    = 3'd5;

    // pending sleep request
    localparam logic [1:0] PEND_NONE  = 2'd0;
    localparam logic [1:0] PEND_SHORT = 2'd1;
    localparam logic [1:0] PEND_RETRY = 2'd2;

    typedef struct packed {
        logic [TimerW-1:0] long_press_ms;
        logic [TimerW-1:0] resume_ignore_ms;
        logic [TimerW-1:0] retry_interval_ms;
        logic [TimerW-1:0] error_after_ms;
        logic [KeyW-1:0]   pwr_key;
    } cfg_t;

    typedef struct packed {
        logic [1:0]      op;
        logic [KeyW-1:0] key_code;
        logic [1:0]      key_value;
        logic            sleep_ok;
    } item_t;

    typedef struct packed {
        logic [2:0] action;
        logic       in_fake_sleep;
    } result_t;

endpackage

### design/power_button_sleep_controller.sv
`timescale 1ns / 1ps
// a result beat passes from the input register through the core into the result register
// throughput: one input beat per cycle while the result register is not stalled by out_ready,
// set by the state update in the core between the input register and the result register
// reset: control state clears, configuration returns to its defaults,
// the retry timer starts at the default retry interval

module power_button_sleep_controller
    import pbsc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  op,
    input  logic [9:0]  key_code,
    input  logic [1:0]  key_value,
    input  logic        sleep_ok,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  action,
    output logic        in_fake_sleep,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    cfg_t    cfg;
    item_t   item_reg;
    logic    item_valid_reg;
    result_t res;
    result_t res_reg;
    logic    out_valid_reg;
    logic    advance;

    assign advance   = item_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !item_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign action        = res_reg.action;
    assign in_fake_sleep = res_reg.in_fake_sleep;

    pbsc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pbsc_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (advance),
        .item  (item_reg),
        .cfg   (cfg),
        .res   (res)
    );

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (in_valid && in_ready)
            item_valid_reg <= 1'b1;
        else if (advance)
            item_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.op        <= op;
            item_reg.key_code  <= key_code;
            item_reg.key_value <= key_value;
            item_reg.sleep_ok  <= sleep_ok;
        end
    end

    // result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= res;
    end

endmodule

### design/pbsc_cfg.sv
`timescale 1ns / 1ps

module pbsc_cfg
    import pbsc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output cfg_t        cfg
);

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.long_press_ms     <= LONG_PRESS_RST;
            cfg_reg.resume_ignore_ms  <= RESUME_IGN_RST;
            cfg_reg.retry_interval_ms <= RETRY_INTV_RST;
            cfg_reg.error_after_ms    <= ERROR_AFTER_RST;
            cfg_reg.pwr_key           <= POWER_KEY_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_LONG_PRESS:  cfg_reg.long_press_ms     <= cfg_data;
                CFG_RESUME_IGN:  cfg_reg.resume_ignore_ms  <= cfg_data;
                CFG_RETRY_INTV:  cfg_reg.retry_interval_ms <= cfg_data;
                CFG_ERROR_AFTER: cfg_reg.error_after_ms    <= cfg_data;
                CFG_POWER_KEY:   cfg_reg.pwr_key           <= cfg_data[KeyW-1:0];
                default:         ;
            endcase
        end
    end

endmodule

### design/pbsc_core.sv
`timescale 1ns / 1ps

module pbsc_core
    import pbsc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    fire,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t res
);

    logic              button_down_reg, button_down_next;
    logic              long_handled_reg, long_handled_next;
    logic              press_valid_reg, press_valid_next;
    logic [TimerW-1:0] press_timer_reg, press_timer_next;
    logic [TimerW-1:0] ignore_timer_reg, ignore_timer_next;
    logic              fake_sleep_reg, fake_sleep_next;
    logic [TimerW-1:0] retry_timer_reg, retry_timer_next;
    logic [TimerW-1:0] fake_timer_reg, fake_timer_next;
    logic              error_shown_reg, error_shown_next;
    logic [1:0]        pending_reg, pending_next;
    logic [2:0]        act;
    logic              key_match;

    function automatic logic [TimerW-1:0] sat_inc(input logic [TimerW-1:0] v);
        return (v == TIMER_MAX) ? v : v + 16'd1;
    endfunction

    assign key_match = (item.key_code == cfg.pwr_key) || (item.key_code == ALT_KEY);

    always_comb
    begin
        button_down_next  = button_down_reg;
        long_handled_next = long_handled_reg;
        press_valid_next  = press_valid_reg;
        press_timer_next  = press_timer_reg;
        ignore_timer_next = ignore_timer_reg;
        fake_sleep_next   = fake_sleep_reg;
        retry_timer_next  = retry_timer_reg;
        fake_timer_next   = fake_timer_reg;
        error_shown_next  = error_shown_reg;
        pending_next      = pending_reg;
        act               = ACT_NONE;

        unique case (item.op)
            OP_TICK:
            begin
                if (press_valid_reg)
                    press_timer_next = sat_inc(press_timer_reg);
                if (ignore_timer_reg != '0)
                    ignore_timer_next = ignore_timer_reg - 16'd1;
                retry_timer_next = sat_inc(retry_timer_reg);
                if (fake_sleep_reg)
                    fake_timer_next = sat_inc(fake_timer_reg);
                if (button_down_reg && !long_handled_reg && press_valid_reg &&
                    press_timer_next >= cfg.long_press_ms)
                begin
                    long_handled_next = 1'b1;
                    button_down_next  = 1'b0;
                    act               = ACT_SHUTDOWN;
                end
                else if (fake_sleep_reg && pending_reg == PEND_NONE &&
                         retry_timer_next >= cfg.retry_interval_ms)
                begin
                    retry_timer_next = '0;
                    pending_next     = PEND_RETRY;
                    act              = ACT_SLEEP;
                end
            end
            OP_KEY:
            begin
                if (key_match && pending_reg == PEND_NONE)
                begin
                    if (ignore_timer_reg != '0)
                    begin
                        if (item.key_value == KEY_RELEASE)
                        begin
                            button_down_next  = 1'b0;
                            long_handled_next = 1'b0;
                            press_valid_next  = 1'b0;
                        end
                    end
                    else
                    begin
                        case (item.key_value)
                            KEY_PRESS:
                            begin
                                if (fake_sleep_reg)
                                begin
                                    fake_sleep_next   = 1'b0;
                                    button_down_next  = 1'b0;
                                    long_handled_next = 1'b0;
                                    press_valid_next  = 1'b0;
                                    act               = ACT_FAKE_OFF;
                                end
                                else
                                begin
                                    button_down_next  = 1'b1;
                                    long_handled_next = 1'b0;
                                    press_valid_next  = 1'b1;
                                    press_timer_next  = '0;
                                end
                            end
                            KEY_RELEASE:
                            begin
                                if (press_valid_reg)
                                begin
                                    if (!long_handled_reg &&
                                        press_timer_reg < cfg.long_press_ms)
                                    begin
                                        pending_next = PEND_SHORT;
                                        act          = ACT_SLEEP;
                                    end
                                    button_down_next  = 1'b0;
                                    long_handled_next = 1'b0;
                                    press_valid_next  = 1'b0;
                                end
                            end
                            default: ;
                        endcase
                        if (act == ACT_NONE && button_down_next && !long_handled_next &&
                            press_valid_next && press_timer_next >= cfg.long_press_ms)
                        begin
                            long_handled_next = 1'b1;
                            button_down_next  = 1'b0;
                            act               = ACT_SHUTDOWN;
                        end
                    end
                end
            end
            OP_OUTCOME:
            begin
                if (pending_reg == PEND_SHORT)
                begin
                    if (item.sleep_ok)
                        ignore_timer_next = cfg.resume_ignore_ms;
                    else
                    begin
                        fake_sleep_next = 1'b1;
                        fake_timer_next = '0;
                        act             = ACT_FAKE_ON;
                    end
                end
                else if (pending_reg == PEND_RETRY)
                begin
                    if (item.sleep_ok)
                    begin
                        error_shown_next = 1'b0;
                        fake_sleep_next  = 1'b0;
                        act              = ACT_FAKE_OFF;
                    end
                    else if (fake_timer_reg >= cfg.error_after_ms && !error_shown_reg)
                    begin
                        error_shown_next = 1'b1;
                        act              = ACT_ERROR;
                    end
                end
                pending_next = PEND_NONE;
            end
            default: ;
        endcase
    end

    assign res.action        = act;
    assign res.in_fake_sleep = fake_sleep_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            button_down_reg  <= 1'b0;
            long_handled_reg <= 1'b0;
            press_valid_reg  <= 1'b0;
            press_timer_reg  <= '0;
            ignore_timer_reg <= '0;
            fake_sleep_reg   <= 1'b0;
            retry_timer_reg  <= RETRY_INTV_RST;
            fake_timer_reg   <= '0;
            error_shown_reg  <= 1'b0;
            pending_reg      <= PEND_NONE;
        end
        else if (fire)
        begin
            button_down_reg  <= button_down_next;
            long_handled_reg <= long_handled_next;
            press_valid_reg  <= press_valid_next;
            press_timer_reg  <= press_timer_next;
            ignore_timer_reg <= ignore_timer_next;
            fake_sleep_reg   <= fake_sleep_next;
            retry_timer_reg  <= retry_timer_next;
            fake_timer_reg   <= fake_timer_next;
            error_shown_reg  <= error_shown_next;
            pending_reg      <= pending_next;
        end
    end

    // an outcome always closes the pending request
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.op == OP_OUTCOME |=> pending_reg == PEND_NONE)
        else $error("pending request survived an outcome");

    assert property (@(posedge clk) disable iff (!rst_n)
        fire && res.action == ACT_FAKE_ON |-> res.in_fake_sleep)
        else $error("fake sleep on without fake sleep flag");

    assert property (@(posedge clk) disable iff (!rst_n)
        fire && res.action == ACT_FAKE_OFF |-> !res.in_fake_sleep)
        else $error("fake sleep off with fake sleep flag");

    // shutdown marks the press as handled
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && res.action == ACT_SHUTDOWN |=> long_handled_reg && !button_down_reg)
        else $error("shutdown left press state open");

    // a sleep request always leaves something pending
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && res.action == ACT_SLEEP |=> pending_reg != PEND_NONE)
        else $error("sleep request without pending state");

endmodule
